// ===== rtl/rrts_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the thread scheduler.
`default_nettype none
package rrts_pkg;

    localparam int THREAD_SLOTS = 16;
    localparam int CPU_COUNT    = 4;
    localparam int SLOT_W       = 4;
    localparam int CPU_W        = 2;
    localparam int CUR_W        = 5;   // slot number or NO_THREAD
    localparam int LEN_W        = 5;   // 0..THREAD_SLOTS
    localparam int COUNT_W      = 16;
    localparam int PRIO_W       = 3;
    localparam int QUANT_W      = 6;
    localparam int KIND_W       = 3;

    localparam logic [CUR_W-1:0]   NO_THREAD    = 5'd16;
    localparam logic [LEN_W-1:0]   LEN_FULL     = 5'd16;
    localparam logic [QUANT_W-1:0] QUANTUM_BASE = 6'd20;
    localparam logic [COUNT_W-1:0] WAIT_MAX     = 16'hFFFF;
    localparam logic [PRIO_W-1:0]  PRIO_TOP     = 3'd7;

    localparam logic [KIND_W-1:0] KIND_SCHEDULE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SLEEP    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WAKE     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CREATE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_KILL     = 3'd4;

    typedef struct packed {
        logic load;      // latch a new transaction
        logic find;      // one step of the ready-list search
        logic exec;      // apply sleep/wake/create/kill
        logic setup;     // set up the schedule walk
        logic walk;      // one step of the schedule walk
        logic out_load;  // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic find_done;
        logic walk_done;
        logic is_sched;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ===== rtl/rrts_ctrl.sv =====
// Sequencing state machine for the thread scheduler.
`default_nettype none
module rrts_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  rrts_pkg::sts_t      sts,
    output rrts_pkg::cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FIND  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_SETUP = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_FIND;
                end
            end
            ST_FIND:
            begin
                cmd.find = 1'b1;
                if (sts.find_done)
                    state_next = sts.is_sched ? ST_SETUP : ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.walk_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ===== rtl/rrts_datapath.sv =====
// Scheduler state, ready-list search and walk, and the result/output registers.
`default_nettype none
module rrts_datapath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  rrts_pkg::cmd_t                   cmd,
    output rrts_pkg::sts_t                   sts,
    input  wire  [rrts_pkg::KIND_W-1:0]      in_kind,
    input  wire  [rrts_pkg::SLOT_W-1:0]      in_slot,
    input  wire  [rrts_pkg::CPU_W-1:0]       in_cpu,
    input  wire  [rrts_pkg::COUNT_W-1:0]     in_count,
    input  wire  [rrts_pkg::PRIO_W-1:0]      in_prio,
    input  wire                              in_susp,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic                             out_ok,
    output logic                             out_switched,
    output logic [rrts_pkg::SLOT_W-1:0]      out_next,
    output logic [rrts_pkg::QUANT_W-1:0]     out_quantum
);

    // latched transaction
    logic [rrts_pkg::KIND_W-1:0]  kind_reg;
    logic [rrts_pkg::SLOT_W-1:0]  slot_reg;
    logic [rrts_pkg::CPU_W-1:0]   cpu_reg;
    logic [rrts_pkg::COUNT_W-1:0] count_reg;
    logic [rrts_pkg::PRIO_W-1:0]  prio_reg;
    logic                         susp_reg;
    logic [rrts_pkg::CUR_W-1:0]   target_reg;

    // search / walk
    logic [rrts_pkg::LEN_W-1:0]   idx_reg;
    logic [rrts_pkg::SLOT_W-1:0]  pos_reg;
    logic                         found_reg;
    logic [rrts_pkg::SLOT_W-1:0]  wp_reg;
    logic [rrts_pkg::LEN_W-1:0]   steps_reg;

    // scheduler state
    logic [rrts_pkg::SLOT_W-1:0]  order_reg [rrts_pkg::THREAD_SLOTS];
    logic [rrts_pkg::LEN_W-1:0]   len_reg;
    logic [rrts_pkg::THREAD_SLOTS-1:0] blocked_reg;
    logic [rrts_pkg::THREAD_SLOTS-1:0] used_reg;
    logic [rrts_pkg::COUNT_W-1:0] wait_reg  [rrts_pkg::THREAD_SLOTS];
    logic [rrts_pkg::PRIO_W-1:0]  tprio_reg [rrts_pkg::THREAD_SLOTS];
    logic [rrts_pkg::CUR_W-1:0]   cur_reg   [rrts_pkg::CPU_COUNT];

    // result and output
    logic                         res_ok_reg, res_sw_reg;
    logic [rrts_pkg::SLOT_W-1:0]  res_next_reg;
    logic [rrts_pkg::QUANT_W-1:0] res_q_reg;
    logic                         out_valid_reg, out_ok_reg, out_sw_reg;
    logic [rrts_pkg::SLOT_W-1:0]  out_next_reg;
    logic [rrts_pkg::QUANT_W-1:0] out_q_reg;

    // single read port on the ready list
    logic [rrts_pkg::SLOT_W-1:0]  rd_addr, rd_data;
    logic                         in_range, match, running, cand_is_cur;
    logic [rrts_pkg::LEN_W-1:0]   pos_inc, wp_inc;
    logic [rrts_pkg::COUNT_W:0]   wait_sum;
    logic [rrts_pkg::COUNT_W-1:0] wait_cur, wait_sat, wait_dec;
    logic                         slot_used, slot_blocked;

    assign rd_addr  = cmd.walk ? wp_reg : idx_reg[rrts_pkg::SLOT_W-1:0];
    assign rd_data  = order_reg[rd_addr];
    assign in_range = idx_reg < len_reg;
    assign match    = in_range && ({1'b0, rd_data} == target_reg);

    always_comb
    begin
        running = 1'b0;
        for (int c = 0; c < rrts_pkg::CPU_COUNT; c++)
            if (cur_reg[c] == {1'b0, rd_data})
                running = 1'b1;
    end

    assign cand_is_cur  = ({1'b0, rd_data} == target_reg);
    assign pos_inc      = {1'b0, pos_reg} + 5'd1;
    assign wp_inc       = {1'b0, wp_reg} + 5'd1;
    assign wait_cur     = wait_reg[slot_reg];
    assign wait_sum     = {1'b0, wait_cur} + {1'b0, count_reg};
    assign wait_sat     = wait_sum[rrts_pkg::COUNT_W] ? rrts_pkg::WAIT_MAX
                                                      : wait_sum[rrts_pkg::COUNT_W-1:0];
    assign wait_dec     = (count_reg > wait_cur) ? '0 : wait_cur - count_reg;
    assign slot_used    = used_reg[slot_reg];
    assign slot_blocked = blocked_reg[slot_reg];

    assign sts.find_done = !in_range || match;
    assign sts.walk_done = (steps_reg >= len_reg) || cand_is_cur || !running;
    assign sts.is_sched  = (kind_reg == rrts_pkg::KIND_SCHEDULE);
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rrts_pkg::THREAD_SLOTS; i++)
            begin
                order_reg[i] <= '0;
                wait_reg[i]  <= '0;
                tprio_reg[i] <= '0;
            end
            tprio_reg[0] <= rrts_pkg::PRIO_TOP;
            len_reg      <= 5'd1;
            blocked_reg  <= '0;
            used_reg     <= {{(rrts_pkg::THREAD_SLOTS-1){1'b0}}, 1'b1};
            for (int c = 0; c < rrts_pkg::CPU_COUNT; c++)
                cur_reg[c] <= rrts_pkg::NO_THREAD;
            cur_reg[0]    <= '0;
            idx_reg       <= '0;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                idx_reg <= '0;
            else if (cmd.find && !sts.find_done)
                idx_reg <= idx_reg + 5'd1;

            if (cmd.setup)
                steps_reg <= '0;
            else if (cmd.walk && !sts.walk_done)
                steps_reg <= steps_reg + 5'd1;

            if (cmd.walk && (steps_reg < len_reg) && !cand_is_cur && !running)
                cur_reg[cpu_reg] <= {1'b0, rd_data};

            if (cmd.exec)
            begin
                unique case (kind_reg)
                    rrts_pkg::KIND_SLEEP:
                    begin
                        if (slot_used && count_reg != '0)
                        begin
                            wait_reg[slot_reg] <= wait_sat;
                            if (!slot_blocked)
                            begin
                                blocked_reg[slot_reg] <= 1'b1;
                                if (found_reg)
                                begin
                                    for (int i = 0; i < rrts_pkg::THREAD_SLOTS - 1; i++)
                                        if (i >= int'(pos_reg))
                                            order_reg[i] <= order_reg[i+1];
                                    len_reg <= len_reg - 5'd1;
                                end
                            end
                        end
                    end
                    rrts_pkg::KIND_WAKE:
                    begin
                        if (slot_used && count_reg != '0 && slot_blocked)
                        begin
                            wait_reg[slot_reg] <= wait_dec;
                            if (wait_dec == '0)
                            begin
                                blocked_reg[slot_reg] <= 1'b0;
                                if (len_reg < rrts_pkg::LEN_FULL)
                                begin
                                    for (int i = 1; i < rrts_pkg::THREAD_SLOTS; i++)
                                        order_reg[i] <= order_reg[i-1];
                                    order_reg[0] <= slot_reg;
                                    len_reg      <= len_reg + 5'd1;
                                end
                            end
                        end
                    end
                    rrts_pkg::KIND_CREATE:
                    begin
                        if (!slot_used)
                        begin
                            used_reg[slot_reg]  <= 1'b1;
                            tprio_reg[slot_reg] <= prio_reg;
                            if (susp_reg)
                            begin
                                wait_reg[slot_reg]    <= 16'd1;
                                blocked_reg[slot_reg] <= 1'b1;
                            end
                            else
                            begin
                                wait_reg[slot_reg]    <= '0;
                                blocked_reg[slot_reg] <= 1'b0;
                                if (len_reg < rrts_pkg::LEN_FULL)
                                begin
                                    order_reg[len_reg[rrts_pkg::SLOT_W-1:0]] <= slot_reg;
                                    len_reg <= len_reg + 5'd1;
                                end
                            end
                        end
                    end
                    rrts_pkg::KIND_KILL:
                    begin
                        if (slot_used)
                        begin
                            if (!slot_blocked && found_reg)
                            begin
                                for (int i = 0; i < rrts_pkg::THREAD_SLOTS - 1; i++)
                                    if (i >= int'(pos_reg))
                                        order_reg[i] <= order_reg[i+1];
                                len_reg <= len_reg - 5'd1;
                            end
                            blocked_reg[slot_reg] <= 1'b0;
                            used_reg[slot_reg]    <= 1'b0;
                            wait_reg[slot_reg]    <= '0;
                            for (int c = 0; c < rrts_pkg::CPU_COUNT; c++)
                                if (cur_reg[c] == {1'b0, slot_reg})
                                    cur_reg[c] <= rrts_pkg::NO_THREAD;
                        end
                    end
                    default: ;
                endcase
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload and result registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= in_kind;
            slot_reg   <= in_slot;
            cpu_reg    <= in_cpu;
            count_reg  <= in_count;
            prio_reg   <= in_prio;
            susp_reg   <= in_susp;
            target_reg <= (in_kind == rrts_pkg::KIND_SCHEDULE) ? cur_reg[in_cpu]
                                                               : {1'b0, in_slot};
        end
        if (cmd.find && sts.find_done)
        begin
            pos_reg   <= idx_reg[rrts_pkg::SLOT_W-1:0];
            found_reg <= match;
        end
        if (cmd.setup)
        begin
            wp_reg       <= (found_reg && pos_inc < len_reg)
                            ? pos_inc[rrts_pkg::SLOT_W-1:0] : '0;
            res_ok_reg   <= 1'b1;
            res_sw_reg   <= 1'b0;
            res_next_reg <= '0;
            res_q_reg    <= '0;
        end
        if (cmd.walk)
        begin
            wp_reg <= (wp_inc >= len_reg) ? '0 : wp_inc[rrts_pkg::SLOT_W-1:0];
            if ((steps_reg < len_reg) && !cand_is_cur && !running)
            begin
                res_sw_reg   <= 1'b1;
                res_next_reg <= rd_data;
                res_q_reg    <= rrts_pkg::QUANTUM_BASE + {1'b0, tprio_reg[rd_data], 2'b00};
            end
        end
        if (cmd.exec)
        begin
            res_sw_reg   <= 1'b0;
            res_next_reg <= '0;
            res_q_reg    <= '0;
            case (kind_reg) inside
                rrts_pkg::KIND_SLEEP, rrts_pkg::KIND_WAKE, rrts_pkg::KIND_KILL:
                    res_ok_reg <= slot_used;
                rrts_pkg::KIND_CREATE:
                    res_ok_reg <= !slot_used;
                default:
                    res_ok_reg <= 1'b0;
            endcase
        end
        if (cmd.out_load)
        begin
            out_ok_reg   <= res_ok_reg;
            out_sw_reg   <= res_sw_reg;
            out_next_reg <= res_next_reg;
            out_q_reg    <= res_q_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_ok       = out_ok_reg;
    assign out_switched = out_sw_reg;
    assign out_next     = out_next_reg;
    assign out_quantum  = out_q_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= rrts_pkg::LEN_FULL)
        else $error("ready list longer than slot count");

    a_blocked_used: assert property (@(posedge clk) disable iff (!rst_n)
        (blocked_reg & ~used_reg) == '0)
        else $error("blocked mark on a free slot");

    a_quantum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_sw_reg |-> out_q_reg == '0 && out_next_reg == '0)
        else $error("quantum or thread without a switch");

    a_exec_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> !cmd.exec && !cmd.find)
        else $error("exec not followed by result hand-off");

endmodule
`default_nettype wire

// ===== rtl/round_robin_thread_scheduler_unit.sv =====
// Top level of the round-robin thread scheduler: stream ports, controller and datapath.
// Sequence: the ready list is searched one entry per cycle, then the exec step follows,
//   or for schedule the setup step and a walk of the ready list; then the result moves
//   to the output register once that register is free.
// Throughput: one transaction at a time; the controller takes a new one only in its idle state.
// Reset (rst_n low, asynchronous): slot 0 alone exists, is ready and runs on CPU 0.
`default_nettype none
module round_robin_thread_scheduler_unit (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // thread_slot[3:0], cpu_index[5:4], count[21:6], priority_req[24:22],
    // start_suspended[25], zero fill [31:26]
    input  wire  [31:0] s_tdata,
    // kind[2:0]
    input  wire  [2:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // ok[0], switched[1], next_thread[5:2], quantum[11:6], zero fill [15:12]
    output logic [15:0] m_tdata
);

    rrts_pkg::cmd_t cmd;
    rrts_pkg::sts_t sts;

    logic                             ok, switched;
    logic [rrts_pkg::SLOT_W-1:0]      next_thread;
    logic [rrts_pkg::QUANT_W-1:0]     quantum;

    // Controller accepts only when idle; the output register lets the next
    // transaction in while a result still waits downstream.
    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrts_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_kind      (s_tuser),
        .in_slot      (s_tdata[3:0]),
        .in_cpu       (s_tdata[5:4]),
        .in_count     (s_tdata[21:6]),
        .in_prio      (s_tdata[24:22]),
        .in_susp      (s_tdata[25]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_ok       (ok),
        .out_switched (switched),
        .out_next     (next_thread),
        .out_quantum  (quantum)
    );

    assign m_tdata = {4'd0, quantum, next_thread, switched, ok};

endmodule
`default_nettype wire

// ===== tb/round_robin_thread_scheduler_unit_tb.sv =====
// Self-checking testbench for the round-robin thread scheduler: predicted results vs. stream output.
`default_nettype none
module round_robin_thread_scheduler_unit_tb;

    // One scheduler request as it travels on the slave side.
    typedef struct {
        logic [rrts_pkg::KIND_W-1:0]  kind;
        logic [rrts_pkg::SLOT_W-1:0]  slot;
        logic [rrts_pkg::CPU_W-1:0]   cpu;
        logic [rrts_pkg::COUNT_W-1:0] amount;
        logic [rrts_pkg::PRIO_W-1:0]  prio;
        logic                         suspend;
    } sched_req_t;

    // One decision as it leaves on the master side.
    typedef struct {
        logic                         ok;
        logic                         switched;
        logic [rrts_pkg::SLOT_W-1:0]  next_thread;
        logic [rrts_pkg::QUANT_W-1:0] quantum;
    } sched_resp_t;

    // Scoreboard: its own copy of the scheduler state, and the queue of
    // decisions not yet seen on the output.
    class sched_scoreboard;
        logic [rrts_pkg::SLOT_W-1:0]  ready_q [$];
        logic                         blocked [rrts_pkg::THREAD_SLOTS];
        logic                         used [rrts_pkg::THREAD_SLOTS];
        logic [rrts_pkg::COUNT_W-1:0] waits [rrts_pkg::THREAD_SLOTS];
        logic [rrts_pkg::PRIO_W-1:0]  prio [rrts_pkg::THREAD_SLOTS];
        logic [rrts_pkg::CUR_W-1:0]   running [rrts_pkg::CPU_COUNT];
        sched_resp_t                  pending_decisions [$];
        int                           errors;

        function new();
            for (int s = 0; s < rrts_pkg::THREAD_SLOTS; s++)
            begin
                blocked[s] = 0;
                used[s] = 0;
                waits[s] = 0;
                prio[s] = 0;
            end
            for (int c = 0; c < rrts_pkg::CPU_COUNT; c++)
                running[c] = rrts_pkg::NO_THREAD;
            ready_q = '{4'd0};
            used[0] = 1;
            prio[0] = rrts_pkg::PRIO_TOP;
            running[0] = 5'd0;
            errors = 0;
        endfunction

        function int find_ready(logic [rrts_pkg::SLOT_W-1:0] s);
            foreach (ready_q[i])
                if (ready_q[i] == s)
                    return i;
            return -1;
        endfunction

        function bit is_running(logic [rrts_pkg::SLOT_W-1:0] s);
            for (int c = 0; c < rrts_pkg::CPU_COUNT; c++)
                if (running[c] == {1'b0, s})
                    return 1;
            return 0;
        endfunction

        // Apply one accepted request and queue its decision.
        function void note_request(sched_req_t r);
            sched_resp_t d;
            int          pos;
            int          len;
            int          first;
            int          w;
            logic [rrts_pkg::SLOT_W-1:0] cand;
            d = '{ok: 0, switched: 0, next_thread: 0, quantum: 0};
            case (r.kind)
                rrts_pkg::KIND_SCHEDULE:
                begin
                    d.ok = 1;
                    len = ready_q.size();
                    pos = (running[r.cpu] == rrts_pkg::NO_THREAD) ? -1
                        : find_ready(running[r.cpu][rrts_pkg::SLOT_W-1:0]);
                    first = (pos >= 0) ? pos + 1 : 0;
                    for (int i = 0; i < len; i++)
                    begin
                        cand = ready_q[(first + i) % len];
                        if ({1'b0, cand} == running[r.cpu])
                            break;
                        if (!is_running(cand))
                        begin
                            d.switched = 1;
                            d.next_thread = cand;
                            break;
                        end
                    end
                    if (d.switched)
                    begin
                        d.quantum = rrts_pkg::QUANTUM_BASE + 6'(4 * prio[d.next_thread]);
                        running[r.cpu] = {1'b0, d.next_thread};
                    end
                end
                rrts_pkg::KIND_SLEEP:
                    if (used[r.slot])
                    begin
                        d.ok = 1;
                        if (r.amount != 0)
                        begin
                            w = waits[r.slot] + r.amount;
                            waits[r.slot] = (w > rrts_pkg::WAIT_MAX) ? rrts_pkg::WAIT_MAX
                                                                     : w[15:0];
                            if (!blocked[r.slot])
                            begin
                                pos = find_ready(r.slot);
                                if (pos >= 0)
                                    ready_q.delete(pos);
                                blocked[r.slot] = 1;
                            end
                        end
                    end
                rrts_pkg::KIND_WAKE:
                    if (used[r.slot])
                    begin
                        d.ok = 1;
                        if (r.amount != 0 && blocked[r.slot])
                        begin
                            waits[r.slot] = (r.amount > waits[r.slot]) ? '0
                                          : waits[r.slot] - r.amount;
                            if (waits[r.slot] == 0)
                            begin
                                blocked[r.slot] = 0;
                                ready_q.push_front(r.slot);
                            end
                        end
                    end
                rrts_pkg::KIND_CREATE:
                    if (!used[r.slot])
                    begin
                        d.ok = 1;
                        used[r.slot] = 1;
                        prio[r.slot] = r.prio;
                        waits[r.slot] = r.suspend ? 16'd1 : 16'd0;
                        blocked[r.slot] = r.suspend;
                        if (!r.suspend)
                            ready_q.push_back(r.slot);
                    end
                rrts_pkg::KIND_KILL:
                    if (used[r.slot])
                    begin
                        d.ok = 1;
                        if (!blocked[r.slot])
                        begin
                            pos = find_ready(r.slot);
                            if (pos >= 0)
                                ready_q.delete(pos);
                        end
                        blocked[r.slot] = 0;
                        used[r.slot] = 0;
                        waits[r.slot] = 0;
                        for (int c = 0; c < rrts_pkg::CPU_COUNT; c++)
                            if (running[c] == {1'b0, r.slot})
                                running[c] = rrts_pkg::NO_THREAD;
                    end
                default: ;
            endcase
            pending_decisions.push_back(d);
        endfunction

        function void check_decision(sched_resp_t got);
            sched_resp_t exp;
            if (pending_decisions.size() == 0)
            begin
                $error("unexpected output transaction %p", got);
                errors++;
                return;
            end
            exp = pending_decisions.pop_front();
            if (got.ok !== exp.ok)
            begin
                $error("ok: expected %0d, got %0d", exp.ok, got.ok);
                errors++;
            end
            if (got.switched !== exp.switched)
            begin
                $error("switched: expected %0d, got %0d", exp.switched, got.switched);
                errors++;
            end
            if (got.next_thread !== exp.next_thread)
            begin
                $error("next_thread: expected %0d, got %0d", exp.next_thread,
                       got.next_thread);
                errors++;
            end
            if (got.quantum !== exp.quantum)
            begin
                $error("quantum: expected %0d, got %0d", exp.quantum, got.quantum);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // thread_slot, cpu_index, count, priority_req, start_suspended
    logic [2:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // ok, switched, next_thread, quantum

    sched_scoreboard sb;
    bit              stimulus_done;
    int              long_stall_cycles;   // receiver holds off while this is nonzero

    round_robin_thread_scheduler_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Present one request, hold it until the handshake, then an idle gap of random length, possibly none.
    // valid drops only after the gap is drawn as nonzero, so it never gets
    // two nonblocking writes in one step.
    task automatic send_request(sched_req_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {6'd0, r.suspend, r.prio, r.amount, r.cpu, r.slot};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(r);
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;   // back-to-back stretches
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic sched_req_t make_req(logic [2:0] k, int s, int c, int n,
                                            int p, int susp);
        sched_req_t r;
        r.kind = k;
        r.slot = 4'(s);
        r.cpu = 2'(c);
        r.amount = 16'(n);
        r.prio = 3'(p);
        r.suspend = susp[0];
        return r;
    endfunction

    // Mostly legal operations over all slots, most kills turned into creates, so threads live long enough
    // to be scheduled, slept and woken; the rest is full random noise.
    function automatic sched_req_t random_req();
        sched_req_t r;
        int         sel;
        r.kind = 3'($urandom_range(0, 4));
        r.slot = 4'($urandom_range(0, 15));
        r.cpu = 2'($urandom_range(0, 3));
        r.prio = 3'($urandom_range(0, 7));
        r.suspend = $urandom_range(0, 3) == 0;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            r.amount = 16'($urandom_range(1, 3));
        else if (sel < 8)
            r.amount = 16'($urandom);
        else
            r.amount = (sel == 8) ? '0 : rrts_pkg::WAIT_MAX;
        if ($urandom_range(0, 9) == 0)
            r.kind = 3'($urandom_range(5, 7));
        else if ($urandom_range(0, 2) == 0)
            r.kind = rrts_pkg::KIND_SCHEDULE;
        else if (r.kind == rrts_pkg::KIND_KILL && $urandom_range(0, 2) != 0)
            r.kind = rrts_pkg::KIND_CREATE;
        return r;
    endfunction

    // Receiver: random ready with a random hold-off per transaction.
    initial
    begin
        int          gap;
        sched_resp_t got;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_stall_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (long_stall_cycles) @(posedge clk);
                long_stall_cycles = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            got.ok = m_tdata[0];
            got.switched = m_tdata[1];
            got.next_thread = m_tdata[5:2];
            got.quantum = m_tdata[11:6];
            sb.check_decision(got);
        end
    end

    initial
    begin
        sb = new();
        stimulus_done = 0;
        long_stall_cycles = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: each operation, field extremes, corner cases.
        send_request(make_req(rrts_pkg::KIND_SCHEDULE, 0, 0, 0, 0, 0));  // only thread runs
        send_request(make_req(rrts_pkg::KIND_SCHEDULE, 15, 3, 65535, 7, 1)); // all running
        send_request(make_req(rrts_pkg::KIND_CREATE, 1, 0, 0, 0, 0));
        send_request(make_req(rrts_pkg::KIND_CREATE, 15, 0, 0, 7, 0));
        send_request(make_req(rrts_pkg::KIND_CREATE, 1, 0, 0, 3, 0));    // slot taken
        send_request(make_req(rrts_pkg::KIND_CREATE, 2, 0, 0, 5, 1));    // suspended
        send_request(make_req(rrts_pkg::KIND_SCHEDULE, 0, 1, 0, 0, 0));
        send_request(make_req(rrts_pkg::KIND_SCHEDULE, 0, 0, 0, 0, 0));
        send_request(make_req(rrts_pkg::KIND_SLEEP, 1, 0, 0, 0, 0));     // zero count
        send_request(make_req(rrts_pkg::KIND_SLEEP, 1, 0, 65535, 0, 0));
        send_request(make_req(rrts_pkg::KIND_SLEEP, 1, 0, 65535, 0, 0)); // saturates
        send_request(make_req(rrts_pkg::KIND_WAKE, 15, 0, 5, 0, 0));     // already ready
        send_request(make_req(rrts_pkg::KIND_WAKE, 1, 0, 1, 0, 0));
        send_request(make_req(rrts_pkg::KIND_WAKE, 1, 0, 65535, 0, 0));  // floor at zero
        send_request(make_req(rrts_pkg::KIND_WAKE, 2, 0, 1, 0, 0));
        send_request(make_req(rrts_pkg::KIND_SLEEP, 9, 0, 4, 0, 0));     // no such thread
        send_request(make_req(rrts_pkg::KIND_KILL, 0, 0, 0, 0, 0));      // ready, but running on no cpu
        send_request(make_req(rrts_pkg::KIND_SCHEDULE, 0, 0, 0, 0, 0));  // current at list end, wraps
        send_request(make_req(rrts_pkg::KIND_KILL, 13, 0, 0, 0, 0));     // empty slot
        send_request(make_req(3'd5, 3, 2, 7, 1, 1));
        send_request(make_req(3'd7, 3, 2, 7, 1, 1));
        send_request(make_req(rrts_pkg::KIND_SCHEDULE, 0, 3, 0, 0, 0));
        send_request(make_req(rrts_pkg::KIND_SCHEDULE, 0, 2, 0, 0, 0));

        for (int i = 0; i < 700; i++)
        begin
            if (i == 300)
                long_stall_cycles = 400;   // output backs up, input must stall
            send_request(random_req());
        end
        s_tvalid <= 1'b0;
        stimulus_done = 1;
    end

    initial
    begin
        wait (stimulus_done);
        while (sb.pending_decisions.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
